>>> sv/bwt_pkg.sv
`timescale 1ns / 1ps
package bwt_pkg;

  typedef logic [7:0] byte_t;

  // End-of-text marker that closes every block
  localparam byte_t SENTINEL = 8'h24;

endpackage

>>> sv/bwt_ram.sv
`timescale 1ns / 1ps
module bwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> sv/bwt_fifo.sv
`timescale 1ns / 1ps
module bwt_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  // Two-entry queue, entry 0 is the head
  logic [WIDTH-1:0] slot_q [2];
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[0];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 2'd0;
      slot_q[0] <= '0;
      slot_q[1] <= '0;
    end else begin
      if (do_pop) begin
        slot_q[0] <= slot_q[1];
      end
      if (do_push) begin
        if (do_pop) begin
          if (cnt_q == 2'd1) slot_q[0] <= data_i;
          else slot_q[1] <= data_i;
        end else if (cnt_q == 2'd0) begin
          slot_q[0] <= data_i;
        end else begin
          slot_q[1] <= data_i;
        end
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> sv/bwt_front.sv
`timescale 1ns / 1ps
module bwt_front #(
  parameter int MAX_LEN = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  bwt_pkg::byte_t               data_byte_i,
  input  logic                         last_i,
  output logic                         we_o,
  output logic [$clog2(MAX_LEN)-1:0]   waddr_o,
  output bwt_pkg::byte_t               wdata_o,
  output logic                         q_push_o,
  output logic [$clog2(MAX_LEN+1):0]   q_desc_o,
  input  logic                         q_full_i,
  input  logic                         done_i
);
  import bwt_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef struct packed {
    logic [CW-1:0] len;
    logic          ovf;
  } desc_t;

  typedef enum logic [1:0] {F_LOAD, F_SENT, F_HOLD} state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  byte_t         lastb_q, lastb_d;
  logic          accept, has_room, need_sent;
  desc_t         desc;

  assign accept    = push && (state_q == F_LOAD);
  assign has_room  = (cnt_q < CW'(MAX_LEN));
  assign need_sent = (lastb_q != SENTINEL);
  assign full      = (state_q != F_LOAD);
  assign q_desc_o  = desc;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    lastb_d  = lastb_q;
    we_o     = 1'b0;
    waddr_o  = cnt_q[AW-1:0];
    wdata_o  = data_byte_i;
    q_push_o = 1'b0;
    desc.len = cnt_q;
    desc.ovf = drop_q;
    unique case (state_q)
      F_LOAD: begin
        if (accept) begin
          if (has_room) begin
            we_o    = 1'b1;
            cnt_d   = cnt_q + CW'(1);
            lastb_d = data_byte_i;
          end else begin
            drop_d = 1'b1;
          end
          if (last_i) state_d = F_SENT;
        end
      end
      F_SENT: begin
        // Append the marker unless the block already ends in one, or overwrite the final byte when the store is full
        wdata_o = SENTINEL;
        if (need_sent) begin
          if (has_room) begin
            desc.len = cnt_q + CW'(1);
          end else begin
            waddr_o  = AW'(MAX_LEN - 1);
            desc.ovf = 1'b1;
          end
        end
        if (!q_full_i) begin
          we_o     = need_sent;
          q_push_o = 1'b1;
          cnt_d    = '0;
          drop_d   = 1'b0;
          state_d  = F_HOLD;
        end
      end
      F_HOLD: begin
        if (done_i) state_d = F_LOAD;
      end
      default: state_d = F_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_LOAD;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      lastb_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      lastb_q <= lastb_d;
    end
  end

endmodule

>>> sv/bwt_back.sv
`timescale 1ns / 1ps
module bwt_back #(
  parameter int MAX_LEN = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [$clog2(MAX_LEN+1):0]   q_desc_i,
  input  logic                         q_empty_i,
  output logic                         q_pop_o,
  output logic [$clog2(MAX_LEN)-1:0]   taddr_a_o,
  output logic [$clog2(MAX_LEN)-1:0]   taddr_b_o,
  input  bwt_pkg::byte_t               tdata_a_i,
  input  bwt_pkg::byte_t               tdata_b_i,
  output logic                         done_o,
  output logic                         empty,
  input  logic                         pop,
  output bwt_pkg::byte_t               bwt_byte_o,
  output logic                         last_res_o,
  output logic                         overflow_o
);
  import bwt_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef struct packed {
    logic [CW-1:0] len;
    logic          ovf;
  } desc_t;

  typedef enum logic [2:0] {
    B_IDLE, B_PAIR, B_CHK, B_CMP, B_STORE, B_ORD, B_TXT, B_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] n_q, n_d, pa_q, pa_d, pb_q, pb_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, rank_q, rank_d;
  logic          ovf_q, ovf_d;
  logic          vld_q, vld_d;
  byte_t         byte_q, byte_d;
  logic          lst_q, lst_d, ofl_q, ofl_d;
  logic          adv, less;
  logic [AW-1:0] pos;
  logic [AW-1:0] n_last;
  desc_t         desc;

  assign desc       = q_desc_i;
  assign n_last     = AW'(n_q - CW'(1));
  assign empty      = !vld_q;
  assign bwt_byte_o = byte_q;
  assign last_res_o = lst_q;
  assign overflow_o = ofl_q;

  // Sorted start positions, written by rank
  bwt_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_order (
    .clk_i     (clk_i),
    .we_i      (state_q == B_STORE),
    .waddr_i   (rank_q),
    .wdata_i   (i_q),
    .raddr_a_i (k_q),
    .raddr_b_i (k_q),
    .rdata_a_o (pos),
    .rdata_b_o ()
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    rank_d    = rank_q;
    ovf_d     = ovf_q;
    vld_d     = vld_q && !pop;
    byte_d    = byte_q;
    lst_d     = lst_q;
    ofl_d     = ofl_q;
    q_pop_o   = 1'b0;
    done_o    = 1'b0;
    adv       = 1'b0;
    less      = 1'b0;
    taddr_a_o = pa_q[AW-1:0];
    taddr_b_o = pb_q[AW-1:0];
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          n_d     = desc.len;
          ovf_d   = desc.ovf;
          i_d     = '0;
          j_d     = '0;
          rank_d  = '0;
          state_d = B_PAIR;
        end
      end
      B_PAIR: begin
        if (j_q == i_q) begin
          adv = 1'b1;
        end else begin
          pa_d    = CW'(j_q);
          pb_d    = CW'(i_q);
          state_d = B_CHK;
        end
      end
      B_CHK: begin
        // Only one suffix can run out first; the shorter ranks lower
        if (pa_q >= n_q || pb_q >= n_q) begin
          less = (pa_q >= n_q);
          adv  = 1'b1;
        end else begin
          state_d = B_CMP;
        end
      end
      B_CMP: begin
        if (tdata_a_i != tdata_b_i) begin
          less = (tdata_a_i < tdata_b_i);
          adv  = 1'b1;
        end else begin
          pa_d    = pa_q + CW'(1);
          pb_d    = pb_q + CW'(1);
          state_d = B_CHK;
        end
      end
      B_STORE: begin
        if (i_q == n_last) begin
          k_d     = '0;
          state_d = B_ORD;
        end else begin
          i_d     = i_q + AW'(1);
          j_d     = '0;
          rank_d  = '0;
          state_d = B_PAIR;
        end
      end
      B_ORD: state_d = B_TXT;
      B_TXT: begin
        taddr_a_o = (pos == '0) ? n_last : pos - AW'(1);
        state_d   = B_EMIT;
      end
      B_EMIT: begin
        taddr_a_o = (pos == '0) ? n_last : pos - AW'(1);
        if (!vld_q || pop) begin
          vld_d  = 1'b1;
          byte_d = tdata_a_i;
          lst_d  = (k_q == n_last);
          ofl_d  = ovf_q;
          if (k_q == n_last) begin
            done_o  = 1'b1;
            state_d = B_IDLE;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = B_ORD;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
    if (adv) begin
      if (less) rank_d = rank_q + AW'(1);
      if (j_q == n_last) begin
        state_d = B_STORE;
      end else begin
        j_d     = j_q + AW'(1);
        state_d = B_PAIR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      n_q     <= '0;
      pa_q    <= '0;
      pb_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      rank_q  <= '0;
      ovf_q   <= 1'b0;
      vld_q   <= 1'b0;
      byte_q  <= '0;
      lst_q   <= 1'b0;
      ofl_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      rank_q  <= rank_d;
      ovf_q   <= ovf_d;
      vld_q   <= vld_d;
      byte_q  <= byte_d;
      lst_q   <= lst_d;
      ofl_q   <= ofl_d;
    end
  end

endmodule

>>> sv/bwt_block_transform_top.sv
`timescale 1ns / 1ps
// Burrows-Wheeler transform of one block of up to MAX_LEN bytes. Push bytes
// one per beat with last_i high on the final one; a '$' marker is appended
// unless the block already ends in one (when the store is full, the final
// byte becomes '$' and overflow_o is set; bytes beyond MAX_LEN are dropped
// and also set overflow_o). After the last beat, full stays high until the
// whole block has been sorted and every result handed to the output register;
// the next block can then be pushed. The sort ranks each suffix by comparing
// it against every other one, one stored byte pair at a time through the two
// read ports of the text memory, checking the ends of both suffixes before
// each byte pair; each suffix start is then stored at its rank. Readout reads
// the start position and then the byte before it, and waits while the output
// register is still full. Results pop in sorted suffix order with last_res_o
// on the final one.
module bwt_block_transform_top #(
  parameter int MAX_LEN = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  bwt_pkg::byte_t data_byte_i,
  input  logic           last_i,
  output logic           empty,
  input  logic           pop,
  output bwt_pkg::byte_t bwt_byte_o,
  output logic           last_res_o,
  output logic           overflow_o
);
  import bwt_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int DW = $clog2(MAX_LEN + 1) + 1;

  logic          we;
  logic [AW-1:0] waddr, taddr_a, taddr_b;
  byte_t         wdata, tdata_a, tdata_b;
  logic          q_push, q_full, q_pop, q_empty, done;
  logic [DW-1:0] q_in, q_out;

  // Front: store incoming bytes and close the block
  bwt_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .q_push_o    (q_push),
    .q_desc_o    (q_in),
    .q_full_i    (q_full),
    .done_i      (done)
  );

  // Text store: written by the front, read at two places by the back
  bwt_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (taddr_a),
    .raddr_b_i (taddr_b),
    .rdata_a_o (tdata_a),
    .rdata_b_o (tdata_b)
  );

  // Block descriptors (length and overflow) handed from front to back
  bwt_fifo #(.WIDTH(DW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  // Back: rank the suffixes, then emit the preceding bytes in rank order
  bwt_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_desc_i   (q_out),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .taddr_a_o  (taddr_a),
    .taddr_b_o  (taddr_b),
    .tdata_a_i  (tdata_a),
    .tdata_b_i  (tdata_b),
    .done_o     (done),
    .empty      (empty),
    .pop        (pop),
    .bwt_byte_o (bwt_byte_o),
    .last_res_o (last_res_o),
    .overflow_o (overflow_o)
  );

endmodule
